/* hw/rtl/date_add_subtract_days_unit_defines.svh */
// Assertion macros shared by the date stepper RTL.
// Depends on nothing; users provide clk and rst in scope.
`ifndef DATE_ADD_SUBTRACT_DAYS_UNIT_DEFINES_SVH
`define DATE_ADD_SUBTRACT_DAYS_UNIT_DEFINES_SVH

`define DASD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`define DASD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/dasd_pkg.sv */
// Types, calendar constants and month length helpers for the date stepper.
// No dependencies.
package dasd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;

  localparam logic [YEAR_W-1:0]  BASE_YEAR     = 14'd1900;
  localparam logic [YEAR_W-1:0]  BASE_YEAR_MOD = 14'd300;
  localparam logic [YEAR_W-1:0]  YEAR_CYCLE    = 14'd400;
  localparam logic [YEAR_W-1:0]  CENTURY       = 14'd100;
  localparam logic [MONTH_W-1:0] JANUARY       = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTHS        = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY     = 5'd1;
  localparam logic [DAY_W-1:0]   DEC_DAYS      = 5'd31;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0] day_count;
    logic               subtract;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               input_invalid;
    logic               underflow;
  } res_t;

  // ymod is the year modulo 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] ymod);
    logic century;
    century = (ymod == CENTURY) || (ymod == YEAR_W'(2 * CENTURY))
           || (ymod == YEAR_W'(3 * CENTURY));
    return (ymod[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m) inside
      FEBRUARY:                 d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/dasd_core.sv */
// Sequencer and day accumulator of the date stepper; one shared adder
// serves the start offset and every month step. Depends on dasd_pkg.
`include "date_add_subtract_days_unit_defines.svh"

module dasd_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  dasd_pkg::req_t  req_data,
  output logic            fin,
  input  logic            take,
  output dasd_pkg::res_t  fin_data
);

  localparam int DB = COUNT_BITS + 2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_FWD    = 6'b001000,
    S_BWD    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                           state, state_next;
  logic [dasd_pkg::DAY_W-1:0]       day, day_next;
  logic [dasd_pkg::MONTH_W-1:0]     mon, mon_next;
  logic [dasd_pkg::YEAR_W-1:0]      yr, yr_next;
  logic [dasd_pkg::YEAR_W-1:0]      ymod, ymod_next;
  logic [COUNT_BITS-1:0]            cnt, cnt_next;
  logic                             sub, sub_next;
  logic                             bad, bad_next;
  logic                             under, under_next;
  logic [DB-1:0]                    acc, acc_next;

  logic                             leap;
  logic [dasd_pkg::DAY_W-1:0]       dim_cur, dim_prev;
  logic                             chk_bad;
  logic [DB-1:0]                    cnt_x, add_a, add_b, sum;
  logic [dasd_pkg::YEAR_W-1:0]      ymod_inc, ymod_dec;

  assign leap     = dasd_pkg::is_leap(ymod);
  assign dim_cur  = dasd_pkg::month_days(mon, leap);
  assign dim_prev = dasd_pkg::month_days(mon - 4'd1, leap);
  assign chk_bad  = (yr < dasd_pkg::BASE_YEAR) || (mon == '0) || (mon > dasd_pkg::MONTHS)
                 || (day == '0) || (day > dim_cur);
  assign cnt_x    = DB'(cnt);
  assign ymod_inc = (ymod == dasd_pkg::YEAR_CYCLE - 14'd1) ? '0 : ymod + 14'd1;
  assign ymod_dec = (ymod == '0) ? dasd_pkg::YEAR_CYCLE - 14'd1 : ymod - 14'd1;

  always_comb begin
    case (state)
      S_CHECK: begin
        add_a = chk_bad ? DB'(dasd_pkg::FIRST_DAY) : DB'(day);
        add_b = sub ? DB'(0) - cnt_x : cnt_x;
      end
      S_BWD: begin
        add_a = acc;
        add_b = (mon == dasd_pkg::JANUARY) ? DB'(dasd_pkg::DEC_DAYS) : DB'(dim_prev);
      end
      default: begin
        add_a = acc;
        add_b = DB'(0) - DB'(dim_cur);
      end
    endcase
  end

  assign sum = add_a + add_b;

  always_comb begin
    state_next = state;
    day_next   = day;
    mon_next   = mon;
    yr_next    = yr;
    ymod_next  = ymod;
    cnt_next   = cnt;
    sub_next   = sub;
    bad_next   = bad;
    under_next = under;
    acc_next   = acc;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          day_next   = req_data.day;
          mon_next   = req_data.month;
          yr_next    = req_data.year;
          ymod_next  = req_data.year;
          cnt_next   = COUNT_BITS'(req_data.day_count);
          sub_next   = req_data.subtract;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (ymod >= dasd_pkg::YEAR_CYCLE) begin
          ymod_next = ymod - dasd_pkg::YEAR_CYCLE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        bad_next   = chk_bad;
        under_next = 1'b0;
        acc_next   = sum;
        if (chk_bad) begin
          mon_next  = dasd_pkg::JANUARY;
          yr_next   = dasd_pkg::BASE_YEAR;
          ymod_next = dasd_pkg::BASE_YEAR_MOD;
        end
        state_next = sub ? S_BWD : S_FWD;
      end
      S_FWD: begin
        if (!sum[DB-1] && (sum != '0)) begin
          acc_next = sum;
          if (mon == dasd_pkg::MONTHS) begin
            mon_next  = dasd_pkg::JANUARY;
            yr_next   = yr + 14'd1;
            ymod_next = ymod_inc;
          end else begin
            mon_next = mon + 4'd1;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_BWD: begin
        if (acc[DB-1] || (acc == '0)) begin
          if (mon == dasd_pkg::JANUARY) begin
            if (yr == dasd_pkg::BASE_YEAR) begin
              under_next = 1'b1;
              state_next = S_DONE;
            end else begin
              acc_next  = sum;
              mon_next  = dasd_pkg::MONTHS;
              yr_next   = yr - 14'd1;
              ymod_next = ymod_dec;
            end
          end else begin
            acc_next = sum;
            mon_next = mon - 4'd1;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    day   <= day_next;
    mon   <= mon_next;
    yr    <= yr_next;
    ymod  <= ymod_next;
    cnt   <= cnt_next;
    sub   <= sub_next;
    bad   <= bad_next;
    under <= under_next;
    acc   <= acc_next;
  end

  assign req_ready = (state == S_IDLE);
  assign fin       = (state == S_DONE);

  always_comb begin
    fin_data.result_day    = under ? dasd_pkg::FIRST_DAY : acc[dasd_pkg::DAY_W-1:0];
    fin_data.result_month  = under ? dasd_pkg::JANUARY : mon;
    fin_data.result_year   = under ? dasd_pkg::BASE_YEAR : yr;
    fin_data.input_invalid = bad;
    fin_data.underflow     = under;
  end

  `DASD_ASSERT_NEXT(a_accept_to_reduce, req_valid && req_ready, state == S_REDUCE, "request lost")
  `DASD_ASSERT_IMPL(a_month_range, state == S_FWD || state == S_BWD, mon != '0 && mon <= 4'd12, "month")
  `DASD_ASSERT_IMPL(a_fwd_positive, state == S_FWD, !acc[DB-1] && acc != '0, "forward day not positive")
  `DASD_ASSERT_IMPL(a_under_sub, state == S_DONE && under, sub, "underflow on forward move")

endmodule

/* hw/rtl/date_add_subtract_days_unit.sv */
// Date stepper top level: request intake, the stepping core and the result register.
// Depends on dasd_pkg and dasd_core.
//
// Moves a Gregorian date forward or backward by a day count, one month per
// clock through a single shared adder. The year is first reduced modulo 400
// by repeated subtraction, the date is then checked, and the sequencer steps
// one month per cycle until the day fits. A 65535-day move crosses about 2150
// months. The core takes one request at a time; the finished result sits in
// an output register, so the next request is taken while the result waits.
`include "date_add_subtract_days_unit_defines.svh"

module date_add_subtract_days_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  dasd_pkg::req_t  req_data,
  output logic            res_valid,
  input  logic            res_ready,
  output dasd_pkg::res_t  res_data
);

  logic           core_fin;
  logic           take;
  dasd_pkg::res_t core_res;

  assign take = !res_valid || res_ready;

  dasd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .fin       (core_fin),
    .take      (take),
    .fin_data  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (core_fin && take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_fin && take) begin
      res_data <= core_res;
    end
  end

  `DASD_ASSERT_NEXT(a_result_loaded, core_fin && take, res_valid, "finished result not presented")

endmodule
